[design/tlf_pkg.sv]
// Package for the text line folder: sequencer state type and character codes.
// No dependencies; used by text_line_folder_top, tlf_checker and the bench.
package tlf_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAB,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_NL,
        ST_SHIFT_RD,
        ST_SHIFT_WR
    } tlf_state_t;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_BLANK = 8'd32;

    localparam logic [5:0] FOLD_WIDTH_RESET = 6'd10;
    localparam logic [5:0] FOLD_WIDTH_MIN   = 6'd2;

endpackage

[design/text_line_folder_top.sv]
// Text line folder, top level: config register, sequencer, output register.
// Depends on tlf_pkg and tlf_line_mem.
//
// Folds a stream of character words into lines no wider than fold_width
// columns (clamped to 2..BUFFER_COLS). Ordinary characters are stored in a
// line buffer memory. A tab is stored as blanks up to the next TAB_STOP
// column (or the fold width), one blank per cycle. A newline with a
// non-empty line emits the buffered columns and a newline word; an empty
// line emits nothing. When the line reaches the fold width, the buffer is
// searched downward from the last column for a blank (each column probed is
// read and then checked, since the memory read is registered), the line
// is emitted up to and including that blank (or whole if none beyond column
// zero), and the tail is copied to the front, a read and a write per column.
// Each emitted word is read from the buffer, then loaded into the output
// register once that register is free; the final newline word of a run
// carries last_of_run and sits in the output register while the block goes
// on with the tail copy or takes the next input word. One input word is
// worked on at a time; in_stall is high while the sequencer is not idle.
// The line buffer holds no reset value; only columns already written are read.
module text_line_folder_top
    import tlf_pkg::*;
#(
    parameter int BUFFER_COLS = 32,
    parameter int TAB_STOP    = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [5:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       last_of_run
);

    localparam int ADDR_W = (BUFFER_COLS > 1) ? $clog2(BUFFER_COLS) : 1;
    localparam int CNT_W  = $clog2(BUFFER_COLS + 1);

    // config register
    logic [5:0] fold_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fold_width_reg <= FOLD_WIDTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            fold_width_reg <= cfg_wr_data;
        end
    end

    // effective width, clamped to 2..BUFFER_COLS
    logic [CNT_W-1:0] w_eff;

    always_comb
    begin
        if (fold_width_reg < FOLD_WIDTH_MIN)
        begin
            w_eff = CNT_W'(2);
        end
        else if ({1'b0, fold_width_reg} > 7'(BUFFER_COLS))
        begin
            w_eff = CNT_W'(BUFFER_COLS);
        end
        else
        begin
            w_eff = CNT_W'(fold_width_reg);
        end
    end

    // next tab stop for each column, capped at the buffer size
    logic [CNT_W-1:0] stop_tbl [BUFFER_COLS];

    for (genvar g = 0; g < BUFFER_COLS; g++)
    begin : g_stop
        localparam int STOP_RAW = ((g / TAB_STOP) + 1) * TAB_STOP;
        localparam int STOP_CAP = (STOP_RAW > BUFFER_COLS) ? BUFFER_COLS : STOP_RAW;
        assign stop_tbl[g] = CNT_W'(STOP_CAP);
    end

    // sequencer registers
    tlf_state_t       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] wid_reg, wid_next;
    logic [CNT_W-1:0] pos_reg, pos_next;    // tab column or search column
    logic [CNT_W-1:0] idx_reg, idx_next;    // emit index or copy destination
    logic [CNT_W-1:0] len_reg, len_next;    // columns to emit (fold cut)
    logic             shift_reg, shift_next;

    // output register
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       last_reg;
    logic       out_free;
    logic       out_load;
    logic [7:0] out_load_char;
    logic       out_load_last;

    // memory port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    // shared terms
    logic             in_accept;
    logic [CNT_W-1:0] w_last;
    logic [CNT_W-1:0] pos_a;
    logic [CNT_W-1:0] pos_a_inc;
    logic [CNT_W-1:0] tab_end;
    logic [CNT_W-1:0] pos_inc;
    logic [CNT_W:0]   src;
    logic             rd_blank;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign w_last    = w_eff - CNT_W'(1);
    assign pos_a     = (fill_reg > w_last) ? w_last : fill_reg;
    assign pos_a_inc = pos_a + CNT_W'(1);
    assign tab_end   = (stop_tbl[pos_a[ADDR_W-1:0]] > w_eff) ? w_eff
                                                             : stop_tbl[pos_a[ADDR_W-1:0]];
    assign pos_inc   = pos_reg + CNT_W'(1);
    assign src       = {1'b0, idx_reg} + {1'b0, len_reg};
    assign rd_blank  = (mem_rdata == CH_BLANK);
    assign out_free  = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_char == CH_TAB)
                    begin
                        state_next = ST_TAB;
                    end
                    else if (in_char == CH_NL)
                    begin
                        state_next = (pos_a == '0) ? ST_IDLE : ST_EMIT_RD;
                    end
                    else if (pos_a == w_last)
                    begin
                        state_next = ST_SRCH_RD;
                    end
                end
            end
            ST_TAB:
            begin
                if (pos_reg >= len_reg)
                begin
                    state_next = (len_reg >= wid_reg) ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_SRCH_RD:
            begin
                state_next = (pos_reg == '0) ? ST_EMIT_RD : ST_SRCH_CHK;
            end
            ST_SRCH_CHK:
            begin
                state_next = rd_blank ? ST_EMIT_RD : ST_SRCH_RD;
            end
            ST_EMIT_RD:
            begin
                state_next = (idx_reg == len_reg) ? ST_EMIT_NL : ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_NL:
            begin
                if (out_free)
                begin
                    state_next = shift_reg ? ST_SHIFT_RD : ST_IDLE;
                end
            end
            ST_SHIFT_RD:
            begin
                state_next = (src >= {1'b0, wid_reg}) ? ST_IDLE : ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                state_next = ST_SHIFT_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        fill_next     = fill_reg;
        wid_next      = wid_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        shift_next    = shift_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_a[ADDR_W-1:0];
        mem_wdata     = in_char;
        mem_raddr     = idx_reg[ADDR_W-1:0];
        out_load      = 1'b0;
        out_load_char = mem_rdata;
        out_load_last = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    mem_we   = 1'b1;
                    wid_next = w_eff;
                    idx_next = '0;
                    if (in_char == CH_TAB)
                    begin
                        mem_wdata = CH_BLANK;
                        pos_next  = pos_a_inc;
                        len_next  = tab_end;
                    end
                    else if (in_char == CH_NL)
                    begin
                        len_next   = pos_a;
                        shift_next = 1'b0;
                        fill_next  = '0;
                    end
                    else if (pos_a == w_last)
                    begin
                        pos_next = w_last;
                    end
                    else
                    begin
                        fill_next = pos_a_inc;
                    end
                end
            end
            ST_TAB:
            begin
                mem_waddr = pos_reg[ADDR_W-1:0];
                mem_wdata = CH_BLANK;
                if (pos_reg < len_reg)
                begin
                    mem_we   = 1'b1;
                    pos_next = pos_inc;
                end
                else if (len_reg >= wid_reg)
                begin
                    // blanks reached the fold width: emit the whole line
                    fill_next  = '0;
                    shift_next = 1'b0;
                end
                else
                begin
                    fill_next = len_reg;
                end
            end
            ST_SRCH_RD:
            begin
                mem_raddr = pos_reg[ADDR_W-1:0];
                if (pos_reg == '0)
                begin
                    // no blank past column zero
                    len_next   = wid_reg;
                    shift_next = 1'b0;
                    fill_next  = '0;
                end
            end
            ST_SRCH_CHK:
            begin
                mem_raddr = pos_reg[ADDR_W-1:0];
                if (rd_blank)
                begin
                    len_next   = pos_inc;
                    shift_next = (pos_inc != wid_reg);
                    fill_next  = '0;
                end
                else
                begin
                    pos_next = pos_reg - CNT_W'(1);
                end
            end
            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_EMIT_NL:
            begin
                out_load_char = CH_NL;
                out_load_last = 1'b1;
                if (out_free)
                begin
                    out_load = 1'b1;
                    idx_next = '0;
                end
            end
            ST_SHIFT_RD:
            begin
                mem_raddr = src[ADDR_W-1:0];
                if (src >= {1'b0, wid_reg})
                begin
                    fill_next = idx_reg;
                end
            end
            ST_SHIFT_WR:
            begin
                mem_raddr = src[ADDR_W-1:0];
                mem_we    = 1'b1;
                mem_waddr = idx_reg[ADDR_W-1:0];
                mem_wdata = mem_rdata;
                idx_next  = idx_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            wid_reg   <= '0;
            pos_reg   <= '0;
            idx_reg   <= '0;
            len_reg   <= '0;
            shift_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            wid_reg   <= wid_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            shift_reg <= shift_next;
        end
    end

    // output register: holds a word until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_char_reg <= out_load_char;
            last_reg     <= out_load_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_char    = out_char_reg;
    assign last_of_run = last_reg;

    tlf_line_mem #(
        .DEPTH  (BUFFER_COLS),
        .ADDR_W (ADDR_W)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule

[design/tlf_line_mem.sv]
// Line buffer memory: one write port, one read port with registered data.
// Depends on nothing; instantiated by text_line_folder_top.
module tlf_line_mem #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/tlf_checker.sv]
// Port-level checker for text_line_folder_top, attached by bind.
// Depends on tlf_pkg.
module tlf_checker
    import tlf_pkg::*;
#(
    parameter int BUFFER_COLS = 32
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_char,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_char,
    input logic       last_of_run
);

    // words delivered since the last end of run
    logic [6:0] run_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cnt_reg <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            run_cnt_reg <= last_of_run ? 7'd0 : (run_cnt_reg + 7'd1);
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last_of_run))
        else $error("stalled output word changed");

    a_last_is_nl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_run |-> out_char == CH_NL)
        else $error("end of run on a word other than newline");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        run_cnt_reg <= 7'(BUFFER_COLS))
        else $error("run longer than the line buffer");

    a_tab_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_char == CH_TAB |=> in_stall)
        else $error("tab did not start blank fill");

endmodule

bind text_line_folder_top tlf_checker #(
    .BUFFER_COLS (BUFFER_COLS)
) u_tlf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_char     (in_char),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .last_of_run (last_of_run)
);

[bench/text_line_folder_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for text_line_folder_top: a clocked driver and monitor
// around an in-bench line-fold predictor. Depends on tlf_pkg and the design.
module text_line_folder_top_tb;
    import tlf_pkg::*;

    localparam int BUFFER_COLS = 32;
    localparam int TAB_STOP    = 8;
    // Idle time before a register write. A tab fill or a tail copy can still
    // be running after the last word of a run has left the block.
    localparam int SETTLE_CYCLES = 200;
    // Watchdog bound for a few hundred input words under stalls.
    localparam int CYCLE_LIMIT   = 1000000;

    // One expected output word.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } folded_word_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [5:0] cfg_wr_data = 6'd0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] in_char     = 8'd0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [7:0] out_char;
    logic       last_of_run;

    text_line_folder_top #(
        .BUFFER_COLS(BUFFER_COLS),
        .TAB_STOP   (TAB_STOP)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_char    (in_char),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .last_of_run(last_of_run)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: mirror of the line buffer, fill column and width.
    // ------------------------------------------------------------------
    logic [7:0]   model_line [BUFFER_COLS];
    int           model_fill  = 0;
    logic [5:0]   model_width = FOLD_WIDTH_RESET;

    logic [7:0]   pending_chars [$];   // words waiting for the driver
    folded_word_t folded_q [$];        // words the block owes us, oldest first

    int  issued_count   = 0;
    int  accepted_count = 0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;
    bit  send_idle_on   = 1'b1;
    bit  recv_stall_on  = 1'b1;

    // Columns 0..n-1, then a newline if anything was there.
    function automatic void queue_line(input int n);
        for (int i = 0; i < n; i++)
            folded_q.push_back('{ch: model_line[i], last: 1'b0});
        if (n > 0)
            folded_q.push_back('{ch: CH_NL, last: 1'b0});
    endfunction

    // Expected output for one accepted character.
    function automatic void fold_char(input logic [7:0] c);
        int w;
        int pos;
        int p;
        int cut;
        int k;
        int start_size;
        folded_word_t tail_word;
        start_size = folded_q.size();
        w = int'(model_width);
        if (w < int'(FOLD_WIDTH_MIN))
            w = int'(FOLD_WIDTH_MIN);
        if (w > BUFFER_COLS)
            w = BUFFER_COLS;
        pos = model_fill;
        // width may have shrunk under a partly filled line
        if (pos > w - 1)
            pos = w - 1;
        model_line[pos] = c;
        if (c == CH_TAB)
        begin
            model_line[pos] = CH_BLANK;
            pos++;
            while (pos < w && (pos % TAB_STOP) != 0)
            begin
                model_line[pos] = CH_BLANK;
                pos++;
            end
            if (pos >= w)
            begin
                queue_line(pos);
                pos = 0;
            end
        end
        else if (c == CH_NL)
        begin
            queue_line(pos);
            pos = 0;
        end
        else
        begin
            pos++;
            if (pos >= w)
            begin
                // last blank at or below column w-1; column 0 doesn't count
                p = w - 1;
                while (p > 0 && model_line[p] != CH_BLANK)
                    p--;
                cut = (p == 0) ? w : p + 1;
                queue_line(cut);
                if (cut >= w)
                begin
                    pos = 0;
                end
                else
                begin
                    k = 0;
                    for (int j = cut; j < w; j++)
                    begin
                        model_line[k] = model_line[j];
                        k++;
                    end
                    pos = k;
                end
            end
        end
        model_fill = pos;
        if (folded_q.size() > start_size)
        begin
            tail_word = folded_q.pop_back();
            tail_word.last = 1'b1;
            folded_q.push_back(tail_word);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: holds a word while stalled, otherwise takes the next one or
    // idles now and then. Prediction happens at the edge of acceptance.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_char  <= 8'd0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                fold_char(in_char);
                accepted_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_chars.size() > 0 &&
                    !(send_idle_on && $urandom_range(0, 99) < 8))
                begin
                    in_valid <= 1'b1;
                    in_char  <= pending_chars.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure, every accepted word checked in order.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (folded_q.size() == 0)
                begin
                    $error("unexpected word: out_char %0d last_of_run %0d",
                           out_char, last_of_run);
                    mismatch_count++;
                end
                else
                begin
                    if (out_char !== folded_q[0].ch)
                    begin
                        $error("out_char: expected %0d, got %0d",
                               folded_q[0].ch, out_char);
                        mismatch_count++;
                    end
                    if (last_of_run !== folded_q[0].last)
                    begin
                        $error("last_of_run: expected %0d, got %0d",
                               folded_q[0].last, last_of_run);
                        mismatch_count++;
                    end
                    void'(folded_q.pop_front());
                end
            end
            out_stall <= recv_stall_on && ($urandom_range(0, 99) < 8);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c);
        pending_chars.push_back(c);
        issued_count++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // Block is idle once every word is taken and every result is back,
    // plus room for a tab fill or tail copy that emits nothing.
    task automatic wait_idle();
        while (accepted_count != issued_count || folded_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_width(input logic [5:0] w);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_width = w;
    endtask

    // Mostly words and blanks so lines run long enough to fold; some tabs,
    // line breaks and arbitrary bytes mixed in.
    task automatic send_random_text(input int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                send_char(8'($urandom_range(0, 255)));
            else if (r < 27)
                send_char(CH_BLANK);
            else if (r < 32)
                send_char(CH_TAB);
            else if (r < 36)
                send_char(CH_NL);
            else
                send_char(8'($urandom_range(8'h21, 8'h7E)));
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset width: empty newline vanishes, short line, byte extremes,
        // tab to the stop, then a fold at a blank leaving a tail.
        send_char(CH_NL);
        send_text("ab");
        send_char(CH_NL);
        send_char(8'h00);
        send_char(8'hFF);
        send_text(" cd");
        send_char(CH_TAB);
        send_text("ef");
        wait_idle();

        // Narrow: flush the tail, blank only in column zero, no blank at
        // all, then a tab that runs into the fold column.
        set_width(6'd4);
        send_char(CH_NL);
        send_text(" abcwxyzq");
        send_char(CH_TAB);
        wait_idle();

        // Shrink under a partly filled line: fill drops to width-1.
        set_width(6'd32);
        send_text("abcde");
        wait_idle();
        set_width(6'd0);
        send_char("z");
        wait_idle();

        // Random phases over the width range, extremes included.
        set_width(6'd63);
        send_random_text(20);
        wait_idle();
        set_width(6'd1);
        send_random_text(20);
        wait_idle();
        set_width(6'd2);
        send_random_text(20);
        wait_idle();
        // long stretch with no idling on either side
        send_idle_on  = 1'b0;
        recv_stall_on = 1'b0;
        set_width(6'd32);
        send_random_text(30);
        wait_idle();
        send_idle_on  = 1'b1;
        recv_stall_on = 1'b1;
        set_width(6'd33);
        send_random_text(20);
        wait_idle();
        set_width(6'd8);
        send_random_text(20);
        wait_idle();
        set_width(6'd3);
        send_random_text(20);
        wait_idle();
        set_width(6'($urandom_range(2, 32)));
        send_random_text(20);
        wait_idle();
        set_width(6'($urandom_range(0, 63)));
        send_random_text(15);
        wait_idle();
        set_width(6'd10);
        send_random_text(15);
        wait_idle();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
